>>> design/esc_pkg.sv
// Shared types, constants and calendar helper functions for the epoch seconds converter.
package esc_pkg;

  // Calendar constants.
  localparam logic [11:0] EpochYear      = 12'd1970;
  localparam logic [31:0] SecsLeapYear   = 32'd31622400;
  localparam logic [31:0] SecsCommonYear = 32'd31536000;
  localparam logic [31:0] SecsDay        = 32'd86400;
  localparam logic [31:0] SecsHour       = 32'd3600;
  localparam logic [31:0] SecsMinute     = 32'd60;

  // Action codes.
  localparam logic ActDateToSecs = 1'b0;
  localparam logic ActSecsToDate = 1'b1;

  // One request word.
  typedef struct packed {
    logic        action;
    logic [31:0] seconds;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } esc_req_t;

  // One result word.
  typedef struct packed {
    logic [31:0] seconds;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } esc_res_t;

  // Request to the shared add/subtract unit.
  typedef struct packed {
    logic        sub;
    logic [31:0] a;
    logic [31:0] b;
  } esc_alu_req_t;

  // Answer of the shared add/subtract unit.
  typedef struct packed {
    logic [31:0] res;
    logic        borrow;
  } esc_alu_rsp_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } esc_stat_t;

  // Gregorian leap year test by a short chain of compare-and-subtract steps.
  function automatic logic esc_is_leap(input logic [11:0] y);
    logic [11:0] r;
    logic        div400;
    r = y;
    if (r >= 12'd3200) r = r - 12'd3200;
    if (r >= 12'd1600) r = r - 12'd1600;
    if (r >= 12'd800)  r = r - 12'd800;
    if (r >= 12'd400)  r = r - 12'd400;
    div400 = (r == 12'd0);
    if (r >= 12'd200)  r = r - 12'd200;
    if (r >= 12'd100)  r = r - 12'd100;
    return ((y[1:0] == 2'd0) && (r != 12'd0)) || div400;
  endfunction

  // Length of month m (1 to 11 used) in seconds.
  function automatic logic [31:0] esc_month_secs(input logic [3:0] m, input logic leap);
    logic [4:0] days;
    case (m)
      4'd2:    days = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   days = 5'd30;
      default: days = 5'd31;
    endcase
    return {27'd0, days} * SecsDay;
  endfunction

  // Seconds in the whole months before month m of a common year.
  function automatic logic [31:0] esc_before_month_secs(input logic [3:0] m);
    logic [8:0] days;
    case (m)
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return {23'd0, days} * SecsDay;
  endfunction

endpackage

>>> design/esc_alu.sv
// Shared 32-bit add/subtract unit with borrow out.
module esc_alu
  import esc_pkg::*;
(
  input  esc_alu_req_t req_i,
  output esc_alu_rsp_t rsp_o
);

  logic [32:0] sum;

  // One adder serves both directions; the top bit is the borrow on subtract.
  always_comb begin
    if (req_i.sub) begin
      sum = {1'b0, req_i.a} - {1'b0, req_i.b};
    end else begin
      sum = {1'b0, req_i.a} + {1'b0, req_i.b};
    end
    rsp_o.res    = sum[31:0];
    rsp_o.borrow = req_i.sub & sum[32];
  end

endmodule

>>> design/esc_ctrl.sv
// Sequencer and working registers that drive the shared add/subtract unit.
module esc_ctrl
  import esc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  esc_req_t  req_i,
  input  logic      take_i,
  output esc_stat_t stat_o,
  output esc_res_t  res_o
);

  // Sequencer states.
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StYear0  = 4'd1;
  localparam logic [3:0] StMon    = 4'd2;
  localparam logic [3:0] StLeapD  = 4'd3;
  localparam logic [3:0] StDay    = 4'd4;
  localparam logic [3:0] StDayM   = 4'd5;
  localparam logic [3:0] StHour   = 4'd6;
  localparam logic [3:0] StMin    = 4'd7;
  localparam logic [3:0] StSec    = 4'd8;
  localparam logic [3:0] StYear1  = 4'd9;
  localparam logic [3:0] StMonth1 = 4'd10;
  localparam logic [3:0] StDayQ   = 4'd11;
  localparam logic [3:0] StHourQ  = 4'd12;
  localparam logic [3:0] StMinQ   = 4'd13;
  localparam logic [3:0] StDone   = 4'd14;

  logic [3:0]   state_q, state_d;
  esc_req_t     req_q;
  logic [31:0]  acc_q, acc_d;
  logic [11:0]  y_q, y_d;
  logic [3:0]   m_q, m_d;
  logic [4:0]   dq_q, dq_d;
  logic [4:0]   hq_q, hq_d;
  logic [5:0]   mq_q, mq_d;
  esc_alu_req_t alu_req;
  esc_alu_rsp_t alu_rsp;
  logic         leap_y;
  logic         leap_in;
  logic         mon_ok;

  esc_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign leap_y  = esc_is_leap(y_q);
  assign leap_in = esc_is_leap(req_q.year);
  assign mon_ok  = (req_q.month >= 4'd2) && (req_q.month <= 4'd12);

  // Next state and operand selection for the shared unit.
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    y_d         = y_q;
    m_d         = m_q;
    dq_d        = dq_q;
    hq_d        = hq_q;
    mq_d        = mq_q;
    alu_req.sub = 1'b0;
    alu_req.a   = acc_q;
    alu_req.b   = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          acc_d   = (req_i.action == ActSecsToDate) ? req_i.seconds : '0;
          y_d     = EpochYear;
          m_d     = 4'd1;
          dq_d    = '0;
          hq_d    = '0;
          mq_d    = '0;
          state_d = (req_i.action == ActSecsToDate) ? StYear1 : StYear0;
        end
      end
      // Date to seconds: add one whole year per cycle.
      StYear0: begin
        alu_req.b = leap_y ? SecsLeapYear : SecsCommonYear;
        if (y_q < req_q.year) begin
          acc_d = alu_rsp.res;
          y_d   = y_q + 12'd1;
        end else begin
          state_d = StMon;
        end
      end
      StMon: begin
        alu_req.b = mon_ok ? esc_before_month_secs(req_q.month) : '0;
        acc_d     = alu_rsp.res;
        state_d   = StLeapD;
      end
      StLeapD: begin
        alu_req.b = (mon_ok && (req_q.month > 4'd2) && leap_in) ? SecsDay : '0;
        acc_d     = alu_rsp.res;
        state_d   = StDay;
      end
      StDay: begin
        alu_req.b = {27'd0, req_q.day} * SecsDay;
        acc_d     = alu_rsp.res;
        state_d   = StDayM;
      end
      // Day numbers start at one, so one day comes off again.
      StDayM: begin
        alu_req.sub = 1'b1;
        alu_req.b   = SecsDay;
        acc_d       = alu_rsp.res;
        state_d     = StHour;
      end
      StHour: begin
        alu_req.b = {27'd0, req_q.hour} * SecsHour;
        acc_d     = alu_rsp.res;
        state_d   = StMin;
      end
      StMin: begin
        alu_req.b = {26'd0, req_q.minute} * SecsMinute;
        acc_d     = alu_rsp.res;
        state_d   = StSec;
      end
      StSec: begin
        alu_req.b = {26'd0, req_q.second};
        acc_d     = alu_rsp.res;
        state_d   = StDone;
      end
      // Seconds to date: take off whole years while they fit.
      StYear1: begin
        alu_req.sub = 1'b1;
        alu_req.b   = leap_y ? SecsLeapYear : SecsCommonYear;
        if (!alu_rsp.borrow) begin
          acc_d = alu_rsp.res;
          y_d   = y_q + 12'd1;
        end else begin
          state_d = StMonth1;
        end
      end
      // Then whole months, stopping at December.
      StMonth1: begin
        alu_req.sub = 1'b1;
        alu_req.b   = esc_month_secs(m_q, leap_y);
        if ((m_q != 4'd12) && !alu_rsp.borrow) begin
          acc_d = alu_rsp.res;
          m_d   = m_q + 4'd1;
        end else begin
          state_d = StDayQ;
        end
      end
      // Days, hours and minutes by counted subtraction.
      StDayQ: begin
        alu_req.sub = 1'b1;
        alu_req.b   = SecsDay;
        if (!alu_rsp.borrow) begin
          acc_d = alu_rsp.res;
          dq_d  = dq_q + 5'd1;
        end else begin
          state_d = StHourQ;
        end
      end
      StHourQ: begin
        alu_req.sub = 1'b1;
        alu_req.b   = SecsHour;
        if (!alu_rsp.borrow) begin
          acc_d = alu_rsp.res;
          hq_d  = hq_q + 5'd1;
        end else begin
          state_d = StMinQ;
        end
      end
      StMinQ: begin
        alu_req.sub = 1'b1;
        alu_req.b   = SecsMinute;
        if (!alu_rsp.borrow) begin
          acc_d = alu_rsp.res;
          mq_d  = mq_q + 6'd1;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (take_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if ((state_q == StIdle) && start_i) begin
      req_q <= req_i;
    end
    acc_q <= acc_d;
    y_q   <= y_d;
    m_q   <= m_d;
    dq_q  <= dq_d;
    hq_q  <= hq_d;
    mq_q  <= mq_d;
  end

  // Result word; fields that the action does not produce are zero.
  always_comb begin
    res_o = '0;
    if (req_q.action == ActDateToSecs) begin
      res_o.seconds = acc_q;
    end else begin
      res_o.year   = y_q;
      res_o.month  = m_q;
      res_o.day    = dq_q + 5'd1;
      res_o.hour   = hq_q;
      res_o.minute = mq_q;
      res_o.second = acc_q[5:0];
    end
  end

  assign stat_o.busy = (state_q != StIdle);
  assign stat_o.done = (state_q == StDone);

endmodule

>>> design/epoch_seconds_calendar_converter.sv
// Top level of the epoch seconds to calendar converter with its output register.
//
// Input channel: in_valid_i / in_stall_o carry one request word. action_i = 0
// turns in_year_i .. in_second_i into seconds since 1970-01-01 00:00:00
// (modulo 2^32); action_i = 1 turns in_seconds_i into year, month, day, hour,
// minute and second. Each request word gives exactly one result word on
// out_valid_o / out_stall_i; fields the action does not produce read zero.
// A single 32-bit add/subtract unit does every addition and subtraction on
// the running total, one step per cycle under the sequencer, so one request
// is worked on at a time and in_stall_o is high meanwhile.
// Action 0 adds one year at a time up to in_year_i, then the months, days,
// hours, minutes and seconds; action 1 takes off whole years, months, days,
// hours and minutes while they fit.
// A new request is taken once the previous result has moved into the output
// register, even while the receiver still stalls it. A stalled result word
// holds steady. Reset clears the sequencer and the output valid flag.
module epoch_seconds_calendar_converter
  import esc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] in_seconds_i,
  input  logic [11:0] in_year_i,
  input  logic [3:0]  in_month_i,
  input  logic [4:0]  in_day_i,
  input  logic [4:0]  in_hour_i,
  input  logic [5:0]  in_minute_i,
  input  logic [5:0]  in_second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_seconds_o,
  output logic [11:0] out_year_o,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic [4:0]  out_hour_o,
  output logic [5:0]  out_minute_o,
  output logic [5:0]  out_second_o
);

  esc_req_t  req;
  esc_res_t  res;
  esc_res_t  out_q;
  esc_stat_t stat;
  logic      start;
  logic      take;
  logic      out_valid_q, out_valid_d;

  // Gather the request word.
  always_comb begin
    req.action  = action_i;
    req.seconds = in_seconds_i;
    req.year    = in_year_i;
    req.month   = in_month_i;
    req.day     = in_day_i;
    req.hour    = in_hour_i;
    req.minute  = in_minute_i;
    req.second  = in_second_i;
  end

  assign in_stall_o = stat.busy;
  assign start      = in_valid_i & ~stat.busy;

  esc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req),
    .take_i  (take),
    .stat_o  (stat),
    .res_o   (res)
  );

  // Output register loads a finished result when it is empty or being drained.
  assign take = stat.done & (~out_valid_q | ~out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_seconds_o = out_q.seconds;
  assign out_year_o    = out_q.year;
  assign out_month_o   = out_q.month;
  assign out_day_o     = out_q.day;
  assign out_hour_o    = out_q.hour;
  assign out_minute_o  = out_q.minute;
  assign out_second_o  = out_q.second;

endmodule

>>> test/tb.sv
// Self-checking testbench for the epoch seconds calendar converter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import esc_pkg::*;

  localparam int unsigned NumItems    = 2000;
  localparam int unsigned StallMax    = 12;
  // Outlasts the busy time of a year-4095 request, during which no handshake happens.
  localparam int unsigned WatchLimit  = 10000;
  localparam int unsigned DrainCycles = 300;

  // Holds the expected result words and compares each delivered word against them.
  class calendar_board;
    esc_res_t    expected_times[$];
    int unsigned errors = 0;

    function bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int unsigned month_days(int unsigned y, int unsigned m);
      int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      return (m == 2 && leap_year(y)) ? 29 : lens[m - 1];
    endfunction

    function bit [31:0] year_secs(int unsigned y);
      return leap_year(y) ? SecsLeapYear : SecsCommonYear;
    endfunction

    // Date and time of day to seconds since the epoch, wrapping at 2^32.
    function bit [31:0] secs_of_date(esc_req_t r);
      bit [31:0]   t;
      int unsigned y;
      int unsigned m;
      t = '0;
      for (y = 1970; y < r.year; y++) t += year_secs(y);
      // Months outside 2..12 count no whole months and no leap day.
      if (r.month >= 2 && r.month <= 12) begin
        for (m = 1; m < r.month; m++) t += month_days(1971, m) * SecsDay;
        if (r.month > 2 && leap_year(r.year)) t += SecsDay;
      end
      // Day 0 wraps below zero; oversized times are weighted as given.
      t += ({27'd0, r.day} - 32'd1) * SecsDay;
      t += {27'd0, r.hour} * SecsHour;
      t += {26'd0, r.minute} * SecsMinute;
      t += {26'd0, r.second};
      return t;
    endfunction

    // Seconds since the epoch to a calendar date and time of day.
    function esc_res_t calendar_of_secs(bit [31:0] ts);
      esc_res_t    c;
      int unsigned y;
      int unsigned m;
      bit [31:0]   len;
      c = '0;
      y = 1970;
      while (ts >= year_secs(y)) begin
        ts -= year_secs(y);
        y++;
      end
      for (m = 1; m < 12; m++) begin
        len = month_days(y, m) * SecsDay;
        if (ts < len) break;
        ts -= len;
      end
      c.year   = 12'(y);
      c.month  = 4'(m);
      c.day    = 5'(ts / SecsDay + 1);
      c.hour   = 5'((ts % SecsDay) / SecsHour);
      c.minute = 6'((ts % SecsHour) / SecsMinute);
      c.second = 6'(ts % SecsMinute);
      return c;
    endfunction

    function esc_res_t convert_time(esc_req_t r);
      esc_res_t c;
      c = '0;
      if (r.action == ActDateToSecs) c.seconds = secs_of_date(r);
      else c = calendar_of_secs(r.seconds);
      return c;
    endfunction

    task report(string what);
      errors++;
      $display("%0t ERROR: %s", $time, what);
    endtask

    function void note_request(esc_req_t r);
      expected_times.push_back(convert_time(r));
    endfunction

    task check_result(esc_res_t got);
      esc_res_t want;
      if (expected_times.size() == 0) begin
        report($sformatf("result word with no request waiting: %p", got));
        return;
      end
      want = expected_times.pop_front();
      if (got.seconds !== want.seconds)
        report($sformatf("seconds got %0d want %0d", got.seconds, want.seconds));
      if (got.year !== want.year)
        report($sformatf("year got %0d want %0d", got.year, want.year));
      if (got.month !== want.month)
        report($sformatf("month got %0d want %0d", got.month, want.month));
      if (got.day !== want.day)
        report($sformatf("day got %0d want %0d", got.day, want.day));
      if (got.hour !== want.hour)
        report($sformatf("hour got %0d want %0d", got.hour, want.hour));
      if (got.minute !== want.minute)
        report($sformatf("minute got %0d want %0d", got.minute, want.minute));
      if (got.second !== want.second)
        report($sformatf("second got %0d want %0d", got.second, want.second));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        action_i;
  logic [31:0] in_seconds_i;
  logic [11:0] in_year_i;
  logic [3:0]  in_month_i;
  logic [4:0]  in_day_i;
  logic [4:0]  in_hour_i;
  logic [5:0]  in_minute_i;
  logic [5:0]  in_second_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] out_seconds_o;
  logic [11:0] out_year_o;
  logic [3:0]  out_month_o;
  logic [4:0]  out_day_o;
  logic [4:0]  out_hour_o;
  logic [5:0]  out_minute_o;
  logic [5:0]  out_second_o;

  calendar_board board;
  bit            quiet_phase = 1'b0;
  int unsigned   idle_cycles = 0;

  epoch_seconds_calendar_converter uut (.*);

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Cycles either side waits before its next word; none in quiet phases.
  function automatic int unsigned pick_wait();
    return quiet_phase ? 0 : $urandom_range(0, StallMax);
  endfunction

  // Date request; the unused seconds field carries noise.
  function automatic esc_req_t date_req(int unsigned y, int unsigned mo, int unsigned d,
                                        int unsigned h, int unsigned mi, int unsigned s);
    esc_req_t r;
    r.action  = ActDateToSecs;
    r.seconds = $urandom();
    r.year    = 12'(y);
    r.month   = 4'(mo);
    r.day     = 5'(d);
    r.hour    = 5'(h);
    r.minute  = 6'(mi);
    r.second  = 6'(s);
    return r;
  endfunction

  // Seconds request; the unused date fields carry noise.
  function automatic esc_req_t secs_req(bit [31:0] s);
    esc_req_t r;
    r         = date_req($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom());
    r.action  = ActSecsToDate;
    r.seconds = s;
    return r;
  endfunction

  // Well-formed date; at a day boundary it is the first or last second of a month.
  function automatic esc_req_t plain_date(bit at_boundary);
    int unsigned y;
    int unsigned m;
    int unsigned last;
    bit          hi;
    y    = $urandom_range(1970, 2106);
    m    = $urandom_range(1, 12);
    last = board.month_days(y, m);
    hi   = ($urandom_range(0, 1) == 1);
    if (at_boundary) return date_req(y, m, hi ? last : 1, hi ? 23 : 0, hi ? 59 : 0, hi ? 59 : 0);
    return date_req(y, m, $urandom_range(1, last), $urandom_range(0, 23),
                    $urandom_range(0, 59), $urandom_range(0, 59));
  endfunction

  // Mostly well-formed conversions, some out-of-range fields, a few very large years.
  function automatic esc_req_t random_word();
    esc_req_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r = plain_date(1'b0);
    end else if (pick < 48) begin
      r = date_req($urandom_range(1900, 2200), $urandom_range(0, 15), $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
    end else if (pick < 51) begin
      r = date_req($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
    end else if (pick < 80) begin
      r = secs_req($urandom());
    end else begin
      // Within one second of the first or last second of a month.
      r = plain_date(1'b1);
      r = secs_req(board.secs_of_date(r) + $urandom_range(0, 2) - 1);
    end
    return r;
  endfunction

  // Offer one request word and hold it until the block takes it.
  task automatic send_word(input esc_req_t r);
    int unsigned gap;
    gap = pick_wait();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    action_i     <= r.action;
    in_seconds_i <= r.seconds;
    in_year_i    <= r.year;
    in_month_i   <= r.month;
    in_day_i     <= r.day;
    in_hour_i    <= r.hour;
    in_minute_i  <= r.minute;
    in_second_i  <= r.second;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(r);
  endtask

  // Result side: stall for a random count, then take the next result word.
  initial begin : receiver
    esc_res_t    got;
    int unsigned hold;
    out_stall_i = 1'b0;
    forever begin
      hold = pick_wait();
      repeat (hold) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got = '{out_seconds_o, out_year_o, out_month_o, out_day_o, out_hour_o, out_minute_o,
              out_second_o};
      board.check_result(got);
    end
  end

  // End the run when no word moves for too long.
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("epoch_seconds_calendar_converter: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned n;
    board        = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = ActDateToSecs;
    in_seconds_i = '0;
    in_year_i    = '0;
    in_month_i   = '0;
    in_day_i     = '0;
    in_hour_i    = '0;
    in_minute_i  = '0;
    in_second_i  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Date to seconds: epoch, last representable second, wrap past 2^32.
    send_word(date_req(1970, 1, 1, 0, 0, 0));
    send_word(date_req(2106, 2, 7, 6, 28, 15));
    send_word(date_req(2106, 12, 31, 23, 59, 59));
    // Leap rules: divisible by 400, by 4, and a century that is not a leap year.
    send_word(date_req(2000, 2, 29, 12, 30, 45));
    send_word(date_req(2000, 3, 1, 0, 0, 0));
    send_word(date_req(2100, 3, 1, 0, 0, 0));
    send_word(date_req(1972, 12, 31, 23, 59, 59));
    // Year before the epoch, month zero and above twelve, day zero.
    send_word(date_req(1969, 6, 15, 8, 0, 0));
    send_word(date_req(0, 0, 0, 0, 0, 0));
    send_word(date_req(1980, 13, 10, 1, 2, 3));
    send_word(date_req(2004, 15, 1, 0, 0, 0));
    // Time fields past their range, and every field at its all-ones value.
    send_word(date_req(2020, 6, 15, 31, 63, 63));
    send_word(date_req(4095, 15, 31, 31, 63, 63));
    // Seconds to date: both ends, year and leap day edges, top bit alone.
    send_word(secs_req(32'd0));
    send_word(secs_req(32'hFFFF_FFFF));
    send_word(secs_req(32'd31535999));
    send_word(secs_req(32'd31536000));
    send_word(secs_req(32'd951782400));
    send_word(secs_req(32'd951868799));
    send_word(secs_req(32'd4107542399));
    send_word(secs_req(32'd4107542400));
    send_word(secs_req(32'h8000_0000));

    // Random part, with runs of no idling on either side.
    for (n = 0; n < NumItems; n++) begin
      if (n % 100 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
      send_word(random_word());
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Wait for every expected word, then watch for stray ones.
    while (board.expected_times.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("epoch_seconds_calendar_converter: match");
    end else begin
      $display("epoch_seconds_calendar_converter: mismatch");
    end
    $finish;
  end

endmodule
